// ----- rtl/sgfg_pkg.sv -----
// Shared types, constants and face group codes of the grid face generator.
`default_nettype none
package sgfg_pkg;

   localparam int MaxPoints = 256;
   localparam int PtW = 9;
   localparam int CntW = 8;
   localparam int IdxW = 24;
   localparam int FaceW = 27;
   localparam int CsrAddrW = 2;
   localparam int CsrDataW = 9;

   localparam logic [CsrAddrW-1:0] CSR_THREE_D  = 2'd0;
   localparam logic [CsrAddrW-1:0] CSR_POINTS_I = 2'd1;
   localparam logic [CsrAddrW-1:0] CSR_POINTS_J = 2'd2;
   localparam logic [CsrAddrW-1:0] CSR_POINTS_K = 2'd3;

   // Face groups.
   localparam logic [3:0] PH_BT2 = 4'd0;
   localparam logic [3:0] PH_LR2 = 4'd1;
   localparam logic [3:0] PH_IH2 = 4'd2;
   localparam logic [3:0] PH_IV2 = 4'd3;
   localparam logic [3:0] PH_FB3 = 4'd4;
   localparam logic [3:0] PH_BT3 = 4'd5;
   localparam logic [3:0] PH_LR3 = 4'd6;
   localparam logic [3:0] PH_II3 = 4'd7;
   localparam logic [3:0] PH_IJ3 = 4'd8;
   localparam logic [3:0] PH_IK3 = 4'd9;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;    // reset counters to the first face and clear the face count
      logic compute;  // latch the products of the current face
      logic finish;   // register the result and step the counters
   } cmd_type;

   typedef struct packed {
      logic busy;
   } status_type;

   // Clamp a raw register value to the legal point range.
   function automatic logic [PtW-1:0] clamp_points(input logic [CsrDataW-1:0] v);
      logic [PtW-1:0] r;
      if (v < PtW'(2)) r = PtW'(2);
      else if (v > PtW'(MaxPoints)) r = PtW'(MaxPoints);
      else r = v;
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/structured_grid_face_generator_unit.sv -----
// Top level of the structured grid face generator.
`default_nettype none
// Gives one face of a structured 2D edge mesh or 3D triangle mesh per request, in
// file order, wrapping after the last face; restart begins at face 0. Each request
// is taken only while idle, then passes the first index product stage and the second
// product stage into the result register; no new request is taken until then.
// A configuration write also restarts the sequence; write only while idle.
module structured_grid_face_generator_unit
   import sgfg_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_restart,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [IdxW-1:0]          rsp_vertex_first,
   output logic [IdxW-1:0]          rsp_vertex_second,
   output logic [IdxW-1:0]          rsp_vertex_third,
   output logic [IdxW-1:0]          rsp_left_cell,
   output logic [IdxW-1:0]          rsp_right_cell,
   output logic                     rsp_far_boundary,
   output logic [FaceW-1:0]         rsp_face_number,
   output logic                     rsp_last,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [CsrAddrW-1:0] csr_index,
   input  wire logic [CsrDataW-1:0] csr_data
);

   logic           three_d_ff;
   logic [PtW-1:0] ni_ff, nj_ff, nk_ff;
   logic           cfg_write, restart_now;
   cmd_type        cmd;

   assign csr_ready = 1'b1;
   assign cfg_write = csr_valid;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         three_d_ff <= 1'b0;
         ni_ff <= PtW'(2);
         nj_ff <= PtW'(2);
         nk_ff <= PtW'(2);
      end else if (cfg_write) begin
         unique case (csr_index)
            CSR_THREE_D:  three_d_ff <= csr_data[0];
            CSR_POINTS_I: ni_ff <= clamp_points(csr_data);
            CSR_POINTS_J: nj_ff <= clamp_points(csr_data);
            CSR_POINTS_K: nk_ff <= clamp_points(csr_data);
            default: ;
         endcase
      end
   end

   // The new mode must be visible when the restart lands, so the start is delayed.
   logic cfg_write_ff;
   always_ff @(posedge clock) begin
      if (reset) cfg_write_ff <= 1'b0;
      else cfg_write_ff <= cfg_write;
   end

   cmd_type dp_cmd;
   always_comb begin
      dp_cmd = cmd;
      dp_cmd.start = cfg_write_ff || restart_now;
   end

   sgfg_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_restart(req_restart), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .cfg_write(cfg_write), .cmd(cmd), .restart_now(restart_now)
   );

   sgfg_datapath u_dp (
      .clock(clock), .reset(reset),
      .three_d(three_d_ff), .ni(ni_ff), .nj(nj_ff), .nk(nk_ff), .cmd(dp_cmd),
      .rsp_vertex_first(rsp_vertex_first), .rsp_vertex_second(rsp_vertex_second),
      .rsp_vertex_third(rsp_vertex_third), .rsp_left_cell(rsp_left_cell),
      .rsp_right_cell(rsp_right_cell), .rsp_far_boundary(rsp_far_boundary),
      .rsp_face_number(rsp_face_number), .rsp_last(rsp_last)
   );

   // A result that waits while stalled keeps the block from taking a request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while result stalled");

   // Compute and finish never happen together.
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.compute && cmd.finish))
      else $error("compute and finish overlap");

   // A finish is always followed by a valid result.
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid)
      else $error("result missing after finish");

endmodule
`default_nettype wire

// ----- rtl/sgfg_ctrl.sv -----
// Controller that sequences each face request through compute and output.
`default_nettype none
module sgfg_ctrl
   import sgfg_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_restart,
   output logic            req_stall,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   input  wire logic       cfg_write,
   output cmd_type         cmd,
   output logic            restart_now
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CALC = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       out_valid_ff, out_valid_in;
   logic       accept;

   // A new request is taken when idle and the output slot is free or draining.
   assign req_stall = (state_ff != ST_IDLE) || (out_valid_ff && rsp_stall);
   assign accept = req_valid && !req_stall;
   assign restart_now = accept && req_restart;
   assign rsp_valid = out_valid_ff;

   always_comb begin
      state_in = state_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      cmd = '0;
      cmd.start = cfg_write || restart_now;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_CALC;
         end
         ST_CALC: begin
            cmd.compute = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            out_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/sgfg_datapath.sv -----
// Face counters, index arithmetic and result register.
`default_nettype none
module sgfg_datapath
   import sgfg_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              three_d,
   input  wire logic [PtW-1:0]    ni,
   input  wire logic [PtW-1:0]    nj,
   input  wire logic [PtW-1:0]    nk,
   input  cmd_type                cmd,
   output logic [IdxW-1:0]        rsp_vertex_first,
   output logic [IdxW-1:0]        rsp_vertex_second,
   output logic [IdxW-1:0]        rsp_vertex_third,
   output logic [IdxW-1:0]        rsp_left_cell,
   output logic [IdxW-1:0]        rsp_right_cell,
   output logic                   rsp_far_boundary,
   output logic [FaceW-1:0]       rsp_face_number,
   output logic                   rsp_last
);

   logic [3:0]       phase_ff, phase_in;
   logic [PtW-1:0]   o_ff, o_in, m_ff, m_in, n_ff, n_in;
   logic [1:0]       s_ff, s_in;
   logic [FaceW-1:0] fc_ff, fc_in;

   logic [PtW-1:0] a, b, c;
   assign a = ni - PtW'(1);
   assign b = nj - PtW'(1);
   assign c = nk - PtW'(1);

   // Group bounds: lo of outer/middle/inner, hi, sub face count.
   function automatic logic [3*PtW+3*PtW+3-1:0] bounds(input logic [3:0] ph);
      logic [PtW-1:0] l0, l1, l2, h0, h1, h2;
      logic [2:0] sb;
      l0 = '0; l1 = '0; l2 = '0;
      h0 = PtW'(1); h1 = PtW'(1); h2 = PtW'(1); sb = 3'd1;
      unique case (ph)
         PH_BT2: begin h2 = a; sb = 3'd2; end
         PH_LR2: begin h2 = b; sb = 3'd2; end
         PH_IH2: begin l1 = PtW'(1); h1 = b; h2 = a; end
         PH_IV2: begin l1 = PtW'(1); h1 = a; h2 = b; end
         PH_FB3: begin h1 = b; h2 = a; sb = 3'd4; end
         PH_BT3: begin h1 = c; h2 = a; sb = 3'd4; end
         PH_LR3: begin h1 = b; h2 = c; sb = 3'd4; end
         PH_II3: begin l0 = PtW'(1); h0 = a; h1 = b; h2 = c; sb = 3'd2; end
         PH_IJ3: begin l0 = PtW'(1); h0 = b; h1 = a; h2 = c; sb = 3'd2; end
         default: begin l0 = PtW'(1); h0 = c; h1 = a; h2 = b; sb = 3'd2; end
      endcase
      return {l0, l1, l2, h0, h1, h2, sb};
   endfunction

   // Point or cell index from the registered k*n+j term, the row length and i.
   function automatic logic [IdxW-1:0] index_of(input logic [2*PtW:0] kj,
                                                 input logic [PtW-1:0] len,
                                                 input logic [PtW-1:0] i);
      return IdxW'(kj) * IdxW'(len) + IdxW'(i);
   endfunction

   logic [3*PtW+3*PtW+2:0] cur_bnd, nxt_bnd;
   logic [PtW-1:0] lo1, lo2, hi0, hi1, hi2;
   logic [2:0]     subs;
   always_comb cur_bnd = bounds(phase_ff);
   assign {lo1, lo2, hi0, hi1, hi2, subs} = cur_bnd[5*PtW+2:0];

   // Next nonempty group after the current one; only interior groups can be empty.
   logic [3:0] next_ph;
   logic       wrap;
   always_comb begin
      next_ph = three_d ? PH_FB3 : PH_BT2;
      wrap = 1'b1;
      unique case (phase_ff)
         PH_BT2: begin next_ph = PH_LR2; wrap = 1'b0; end
         PH_LR2: begin
            wrap = 1'b0;
            if (b > PtW'(1)) next_ph = PH_IH2;
            else if (a > PtW'(1)) next_ph = PH_IV2;
            else wrap = 1'b1;
         end
         PH_IH2: begin
            if (a > PtW'(1)) begin next_ph = PH_IV2; wrap = 1'b0; end
         end
         PH_FB3: begin next_ph = PH_BT3; wrap = 1'b0; end
         PH_BT3: begin next_ph = PH_LR3; wrap = 1'b0; end
         PH_LR3: begin
            wrap = 1'b0;
            if (a > PtW'(1)) next_ph = PH_II3;
            else if (b > PtW'(1)) next_ph = PH_IJ3;
            else if (c > PtW'(1)) next_ph = PH_IK3;
            else wrap = 1'b1;
         end
         PH_II3: begin
            wrap = 1'b0;
            if (b > PtW'(1)) next_ph = PH_IJ3;
            else if (c > PtW'(1)) next_ph = PH_IK3;
            else wrap = 1'b1;
         end
         PH_IJ3: begin
            if (c > PtW'(1)) begin next_ph = PH_IK3; wrap = 1'b0; end
         end
         default: ;
      endcase
   end

   logic [PtW-1:0] nlo0, nlo1, nlo2;
   always_comb nxt_bnd = bounds(next_ph);
   assign {nlo0, nlo1, nlo2} = nxt_bnd[6*PtW+2:3*PtW+3];

   // Face geometry: three vertex triples and left/right cell triples.
   logic [PtW-1:0] vi[3], vj[3], vk[3], ci[2], cj[2], ck[2];
   logic           far;
   logic [PtW-1:0] nkm1, nkm2;
   always_comb begin
      logic [PtW-1:0] p0, p1, p2, u0, u1, u2, w0, w1, w2;
      logic hi_side, half;
      hi_side = s_ff[1];
      half = s_ff[0];
      nkm1 = three_d ? c : '0;
      nkm2 = nk - PtW'(2);
      for (int q = 0; q < 3; q++) begin vi[q] = '0; vj[q] = '0; vk[q] = '0; end
      for (int q = 0; q < 2; q++) begin ci[q] = '0; cj[q] = '0; ck[q] = '0; end
      far = 1'b1;
      p0 = '0; p1 = '0; p2 = '0;
      u0 = '0; u1 = '0; u2 = '0; w0 = '0; w1 = '0; w2 = '0;
      unique case (phase_ff)
         PH_BT2: begin
            if (!s_ff[0]) begin
               vi[0] = n_ff; vi[1] = n_ff + PtW'(1); ci[0] = n_ff;
            end else begin
               vi[0] = n_ff + PtW'(1); vj[0] = b; vi[1] = n_ff; vj[1] = b;
               ci[0] = n_ff; cj[0] = nj - PtW'(2);
            end
         end
         PH_LR2: begin
            if (!s_ff[0]) begin
               vj[0] = n_ff + PtW'(1); vj[1] = n_ff; cj[0] = n_ff;
            end else begin
               vi[0] = a; vj[0] = n_ff; vi[1] = a; vj[1] = n_ff + PtW'(1);
               ci[0] = ni - PtW'(2); cj[0] = n_ff;
            end
         end
         PH_IH2: begin
            vi[0] = n_ff; vj[0] = m_ff; vi[1] = n_ff + PtW'(1); vj[1] = m_ff;
            ci[0] = n_ff; cj[0] = m_ff; ci[1] = n_ff; cj[1] = m_ff - PtW'(1);
            far = 1'b0;
         end
         PH_IV2: begin
            vi[0] = m_ff; vj[0] = n_ff; vi[1] = m_ff; vj[1] = n_ff + PtW'(1);
            ci[0] = m_ff - PtW'(1); cj[0] = n_ff; ci[1] = m_ff; cj[1] = n_ff;
            far = 1'b0;
         end
         default: begin
            unique case (phase_ff)
               PH_FB3: begin
                  p0 = n_ff; p1 = m_ff; p2 = hi_side ? nkm1 : '0; u0 = PtW'(1); w1 = PtW'(1);
                  ci[0] = n_ff; cj[0] = m_ff; ck[0] = hi_side ? nkm2 : '0;
               end
               PH_BT3: begin
                  p0 = n_ff; p1 = hi_side ? b : '0; p2 = m_ff; u0 = PtW'(1); w2 = PtW'(1);
                  ci[0] = n_ff; cj[0] = hi_side ? nj - PtW'(2) : '0; ck[0] = m_ff;
               end
               PH_LR3: begin
                  p0 = hi_side ? a : '0; p1 = m_ff; p2 = n_ff; u1 = PtW'(1); w2 = PtW'(1);
                  ci[0] = hi_side ? ni - PtW'(2) : '0; cj[0] = m_ff; ck[0] = n_ff;
               end
               PH_II3: begin
                  p0 = o_ff; p1 = m_ff; p2 = n_ff; u1 = PtW'(1); w2 = PtW'(1);
                  ci[0] = o_ff - PtW'(1); cj[0] = m_ff; ck[0] = n_ff;
                  ci[1] = o_ff; cj[1] = m_ff; ck[1] = n_ff; far = 1'b0;
               end
               PH_IJ3: begin
                  p0 = m_ff; p1 = o_ff; p2 = n_ff; u0 = PtW'(1); w2 = PtW'(1);
                  ci[0] = m_ff; cj[0] = o_ff - PtW'(1); ck[0] = n_ff;
                  ci[1] = m_ff; cj[1] = o_ff; ck[1] = n_ff; far = 1'b0;
               end
               default: begin
                  p0 = m_ff; p1 = n_ff; p2 = o_ff; u0 = PtW'(1); w1 = PtW'(1);
                  ci[0] = m_ff; cj[0] = n_ff; ck[0] = o_ff - PtW'(1);
                  ci[1] = m_ff; cj[1] = n_ff; ck[1] = o_ff; far = 1'b0;
               end
            endcase
            vi[0] = p0; vj[0] = p1; vk[0] = p2;
            if (!half) begin
               vi[1] = p0 + u0; vj[1] = p1 + u1; vk[1] = p2 + u2;
               vi[2] = p0 + u0 + w0; vj[2] = p1 + u1 + w1; vk[2] = p2 + u2 + w2;
            end else begin
               vi[1] = p0 + u0 + w0; vj[1] = p1 + u1 + w1; vk[1] = p2 + u2 + w2;
               vi[2] = p0 + w0; vj[2] = p1 + w1; vk[2] = p2 + w2;
            end
         end
      endcase
   end

   // First multiply stage: k*nj + j (and the cell form), registered.
   logic [2*PtW:0] vkj_ff[3], ckj_ff[2];
   logic [PtW-1:0] vi_ff[3], ci_ff[2];
   logic           far_ff, is3_ff;
   logic [PtW-1:0] bj, ai;
   assign bj = nj - PtW'(1);
   assign ai = ni - PtW'(1);

   always_ff @(posedge clock) begin
      if (cmd.compute) begin
         for (int q = 0; q < 3; q++) begin
            vkj_ff[q] <= (2*PtW+1)'(vk[q]) * (2*PtW+1)'(nj) + (2*PtW+1)'(vj[q]);
            vi_ff[q] <= vi[q];
         end
         for (int q = 0; q < 2; q++) begin
            ckj_ff[q] <= (2*PtW+1)'(ck[q]) * (2*PtW+1)'(bj) + (2*PtW+1)'(cj[q]);
            ci_ff[q] <= ci[q];
         end
         far_ff <= far;
         is3_ff <= three_d;
      end
   end

   // Counter stepping, evaluated when the face is finished.
   logic last_face;
   always_comb begin
      phase_in = phase_ff; o_in = o_ff; m_in = m_ff; n_in = n_ff; s_in = s_ff;
      fc_in = fc_ff + FaceW'(1);
      last_face = 1'b0;
      if ({1'b0, s_ff} + 3'd1 < subs) s_in = s_ff + 2'd1;
      else begin
         s_in = '0;
         if (n_ff + PtW'(1) < hi2) n_in = n_ff + PtW'(1);
         else begin
            n_in = lo2;
            if (m_ff + PtW'(1) < hi1) m_in = m_ff + PtW'(1);
            else begin
               m_in = lo1;
               if (o_ff + PtW'(1) < hi0) o_in = o_ff + PtW'(1);
               else begin
                  phase_in = next_ph; o_in = nlo0; m_in = nlo1; n_in = nlo2;
                  if (wrap) begin
                     last_face = 1'b1;
                     fc_in = '0;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.start) begin
         phase_ff <= three_d ? PH_FB3 : PH_BT2;
         o_ff <= '0;
         m_ff <= '0;
         n_ff <= '0;
         s_ff <= '0;
         fc_ff <= '0;
      end else if (cmd.finish) begin
         phase_ff <= phase_in;
         o_ff <= o_in;
         m_ff <= m_in;
         n_ff <= n_in;
         s_ff <= s_in;
         fc_ff <= fc_in;
      end
   end

   // Second multiply stage into the result register.
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_vertex_first <= index_of(vkj_ff[0], ni, vi_ff[0]);
         rsp_vertex_second <= index_of(vkj_ff[1], ni, vi_ff[1]);
         rsp_vertex_third <= is3_ff ? index_of(vkj_ff[2], ni, vi_ff[2]) : '0;
         rsp_left_cell <= index_of(ckj_ff[0], ai, ci_ff[0]);
         rsp_right_cell <= far_ff ? '0 : index_of(ckj_ff[1], ai, ci_ff[1]);
         rsp_far_boundary <= far_ff;
         rsp_face_number <= fc_ff;
         rsp_last <= last_face;
      end
   end

endmodule
`default_nettype wire

// ----- verif/structured_grid_face_generator_unit_test.sv -----
// Self-checking testbench for the structured grid face generator unit.
`default_nettype none
module structured_grid_face_generator_unit_test;
   import sgfg_pkg::*;

   typedef struct {
      logic [IdxW-1:0]  v0;
      logic [IdxW-1:0]  v1;
      logic [IdxW-1:0]  v2;
      logic [IdxW-1:0]  lc;
      logic [IdxW-1:0]  rc;
      logic             far;
      logic [FaceW-1:0] num;
      logic             lst;
   } face_type;

   typedef struct {
      logic     restart;
      logic     known;
      face_type face;
   } stim_row_type;

   logic                clock = 0;
   logic                reset = 1;
   logic                req_valid = 0;
   logic                req_stall;
   logic                req_restart = 0;
   logic                rsp_valid;
   logic                rsp_stall = 0;
   logic [IdxW-1:0]     rsp_vertex_first, rsp_vertex_second, rsp_vertex_third;
   logic [IdxW-1:0]     rsp_left_cell, rsp_right_cell;
   logic                rsp_far_boundary;
   logic [FaceW-1:0]    rsp_face_number;
   logic                rsp_last;
   logic                csr_valid = 0;
   logic                csr_ready;
   logic [CsrAddrW-1:0] csr_index = '0;
   logic [CsrDataW-1:0] csr_data = '0;

   structured_grid_face_generator_unit uut (.*);

   always #5 clock = ~clock;

   // Mirror of the mesh configuration and the face walk.
   logic     mesh_3d;
   int       pts_i, pts_j, pts_k;
   int       grp, cnt_o, cnt_m, cnt_n, tri_half;
   int       face_seq;

   face_type     pending_faces[$];
   stim_row_type sent_rows[$];
   int       failures = 0;
   int       cycles = 0;
   bit       sender_gaps = 1;
   bit       receiver_gaps = 1;
   int       hold_cycles = 0;

   function automatic void grid_bounds(input int ph, output int lo0, output int lo1,
                                       output int lo2, output int hi0, output int hi1,
                                       output int hi2, output int subs);
      int a, b, c;
      a = pts_i - 1; b = pts_j - 1; c = pts_k - 1;
      lo0 = 0; lo1 = 0; lo2 = 0; hi0 = 1; hi1 = 1; hi2 = 1; subs = 1;
      case (ph)
         PH_BT2: begin hi2 = a; subs = 2; end
         PH_LR2: begin hi2 = b; subs = 2; end
         PH_IH2: begin lo1 = 1; hi1 = b; hi2 = a; end
         PH_IV2: begin lo1 = 1; hi1 = a; hi2 = b; end
         PH_FB3: begin hi1 = b; hi2 = a; subs = 4; end
         PH_BT3: begin hi1 = c; hi2 = a; subs = 4; end
         PH_LR3: begin hi1 = b; hi2 = c; subs = 4; end
         PH_II3: begin lo0 = 1; hi0 = a; hi1 = b; hi2 = c; subs = 2; end
         PH_IJ3: begin lo0 = 1; hi0 = b; hi1 = a; hi2 = c; subs = 2; end
         default: begin lo0 = 1; hi0 = c; hi1 = a; hi2 = b; subs = 2; end
      endcase
   endfunction

   function automatic bit open_group(input int ph);
      int lo0, lo1, lo2, hi0, hi1, hi2, subs;
      grid_bounds(ph, lo0, lo1, lo2, hi0, hi1, hi2, subs);
      if (lo0 >= hi0 || lo1 >= hi1 || lo2 >= hi2) return 0;
      grp = ph; cnt_o = lo0; cnt_m = lo1; cnt_n = lo2; tri_half = 0;
      return 1;
   endfunction

   function automatic void rewind_mesh();
      void'(open_group(mesh_3d ? PH_FB3 : PH_BT2));
      face_seq = 0;
   endfunction

   // Steps the counters; returns 1 when the walk wrapped to face 0.
   function automatic bit step_walk();
      int lo0, lo1, lo2, hi0, hi1, hi2, subs, ph;
      grid_bounds(grp, lo0, lo1, lo2, hi0, hi1, hi2, subs);
      tri_half++;
      if (tri_half < subs) return 0;
      tri_half = 0;
      cnt_n++;
      if (cnt_n < hi2) return 0;
      cnt_n = lo2;
      cnt_m++;
      if (cnt_m < hi1) return 0;
      cnt_m = lo1;
      cnt_o++;
      if (cnt_o < hi0) return 0;
      for (ph = grp + 1; ph < (mesh_3d ? 10 : 4); ph++)
         if (open_group(ph)) return 0;
      rewind_mesh();
      return 1;
   endfunction

   function automatic logic [IdxW-1:0] point_at(input longint i, input longint j,
                                                 input longint k);
      return IdxW'((k * pts_j + j) * pts_i + i);
   endfunction

   function automatic logic [IdxW-1:0] cell_at(input longint i, input longint j,
                                                input longint k);
      return IdxW'((k * (pts_j - 1) + j) * (pts_i - 1) + i);
   endfunction

   // One triangle of the quad spanned from point p along unit axes u and w.
   function automatic void quad_half(inout face_type f, input int half, input int p0,
                                     input int p1, input int p2, input int u, input int w);
      int u0, u1, u2, w0, w1, w2;
      u0 = (u == 0); u1 = (u == 1); u2 = (u == 2);
      w0 = (w == 0); w1 = (w == 1); w2 = (w == 2);
      f.v0 = point_at(p0, p1, p2);
      if (half == 0) begin
         f.v1 = point_at(p0 + u0, p1 + u1, p2 + u2);
         f.v2 = point_at(p0 + u0 + w0, p1 + u1 + w1, p2 + u2 + w2);
      end else begin
         f.v1 = point_at(p0 + u0 + w0, p1 + u1 + w1, p2 + u2 + w2);
         f.v2 = point_at(p0 + w0, p1 + w1, p2 + w2);
      end
   endfunction

   // Computes the face for one request and advances the walk.
   function automatic face_type next_face(input logic restart);
      face_type f;
      int o, m, n, s, nk, hi;
      if (restart) rewind_mesh();
      o = cnt_o; m = cnt_m; n = cnt_n; s = tri_half;
      nk = mesh_3d ? pts_k : 1;
      hi = s & 1;
      f.v2 = '0; f.rc = '0; f.far = 1;
      case (grp)
         PH_BT2:
            if (s == 0) begin
               f.v0 = point_at(n, 0, 0); f.v1 = point_at(n + 1, 0, 0);
               f.lc = cell_at(n, 0, 0);
            end else begin
               f.v0 = point_at(n + 1, pts_j - 1, 0); f.v1 = point_at(n, pts_j - 1, 0);
               f.lc = cell_at(n, pts_j - 2, 0);
            end
         PH_LR2:
            if (s == 0) begin
               f.v0 = point_at(0, n + 1, 0); f.v1 = point_at(0, n, 0);
               f.lc = cell_at(0, n, 0);
            end else begin
               f.v0 = point_at(pts_i - 1, n, 0); f.v1 = point_at(pts_i - 1, n + 1, 0);
               f.lc = cell_at(pts_i - 2, n, 0);
            end
         PH_IH2: begin
            f.v0 = point_at(n, m, 0); f.v1 = point_at(n + 1, m, 0);
            f.lc = cell_at(n, m, 0); f.rc = cell_at(n, m - 1, 0); f.far = 0;
         end
         PH_IV2: begin
            f.v0 = point_at(m, n, 0); f.v1 = point_at(m, n + 1, 0);
            f.lc = cell_at(m - 1, n, 0); f.rc = cell_at(m, n, 0); f.far = 0;
         end
         PH_FB3: begin
            quad_half(f, hi, n, m, (s < 2) ? 0 : nk - 1, 0, 1);
            f.lc = cell_at(n, m, (s < 2) ? 0 : nk - 2);
         end
         PH_BT3: begin
            quad_half(f, hi, n, (s < 2) ? 0 : pts_j - 1, m, 0, 2);
            f.lc = cell_at(n, (s < 2) ? 0 : pts_j - 2, m);
         end
         PH_LR3: begin
            quad_half(f, hi, (s < 2) ? 0 : pts_i - 1, m, n, 1, 2);
            f.lc = cell_at((s < 2) ? 0 : pts_i - 2, m, n);
         end
         PH_II3: begin
            quad_half(f, hi, o, m, n, 1, 2);
            f.lc = cell_at(o - 1, m, n); f.rc = cell_at(o, m, n); f.far = 0;
         end
         PH_IJ3: begin
            quad_half(f, hi, m, o, n, 0, 2);
            f.lc = cell_at(m, o - 1, n); f.rc = cell_at(m, o, n); f.far = 0;
         end
         default: begin
            quad_half(f, hi, m, n, o, 0, 1);
            f.lc = cell_at(m, n, o - 1); f.rc = cell_at(m, n, o); f.far = 0;
         end
      endcase
      f.num = FaceW'(face_seq);
      face_seq = (face_seq + 1) & ((1 << FaceW) - 1);
      f.lst = step_walk();
      return f;
   endfunction

   function automatic int clamp_count(input int v);
      return (v < 2) ? 2 : (v > MaxPoints) ? MaxPoints : v;
   endfunction

   // Track accepted requests and check accepted results.
   always @(posedge clock) begin
      face_type want, got, calc;
      stim_row_type row;
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("simulation failed");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_vertex_first, rsp_vertex_second, rsp_vertex_third, rsp_left_cell,
                 rsp_right_cell, rsp_far_boundary, rsp_face_number, rsp_last};
         if (pending_faces.size() == 0) begin
            $error("result with no request outstanding");
            failures++;
         end else begin
            want = pending_faces.pop_front();
            if (got.v0 !== want.v0) begin
               $error("vertex_first exp %0d got %0d", want.v0, got.v0); failures++; end
            if (got.v1 !== want.v1) begin
               $error("vertex_second exp %0d got %0d", want.v1, got.v1); failures++; end
            if (got.v2 !== want.v2) begin
               $error("vertex_third exp %0d got %0d", want.v2, got.v2); failures++; end
            if (got.lc !== want.lc) begin
               $error("left_cell exp %0d got %0d", want.lc, got.lc); failures++; end
            if (got.rc !== want.rc) begin
               $error("right_cell exp %0d got %0d", want.rc, got.rc); failures++; end
            if (got.far !== want.far) begin
               $error("far_boundary exp %0d got %0d", want.far, got.far); failures++; end
            if (got.num !== want.num) begin
               $error("face_number exp %0d got %0d", want.num, got.num); failures++; end
            if (got.lst !== want.lst) begin
               $error("last exp %0d got %0d", want.lst, got.lst); failures++; end
         end
      end
      if (!reset && req_valid && !req_stall) begin
         row = sent_rows.pop_front();
         calc = next_face(req_restart);
         pending_faces.push_back(row.known ? row.face : calc);
      end
   end

   // Result side: random stall per result, plus an occasional long hold.
   initial begin
      int s;
      forever begin
         s = receiver_gaps ? $urandom_range(17) : 0;
         if (hold_cycles > 0) begin
            s = hold_cycles;
            hold_cycles = 0;
         end
         if (s > 0) begin
            rsp_stall <= 1;
            repeat (s) @(posedge clock);
         end
         rsp_stall <= 0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Offer one request and wait for it to be taken, then an optional gap.
   task automatic send_request(input logic restart, input logic known, input face_type f);
      int g;
      sent_rows.push_back('{restart, known, f});
      req_valid <= 1;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
      g = sender_gaps ? $urandom_range(17) : 0;
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 0;
      @(posedge clock);
      while (pending_faces.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CsrAddrW-1:0] idx, input int value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= CsrDataW'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      case (idx)
         CSR_THREE_D:  mesh_3d = value[0];
         CSR_POINTS_I: pts_i = clamp_count(value);
         CSR_POINTS_J: pts_j = clamp_count(value);
         default:      pts_k = clamp_count(value);
      endcase
      rewind_mesh();
      @(posedge clock);
   endtask

   // Picks a raw point count: mostly small, sometimes anything the port carries.
   function automatic int pick_count();
      return ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(6);
   endfunction

   stim_row_type directed_rows[] = '{
      // Default 2x2 edge mesh: bottom, top, left and right edges, then the wrap.
      '{0, 1, '{24'd0, 24'd1, 24'd0, 24'd0, 24'd0, 1'b1, 27'd0, 1'b0}},
      '{0, 1, '{24'd3, 24'd2, 24'd0, 24'd0, 24'd0, 1'b1, 27'd1, 1'b0}},
      '{0, 1, '{24'd2, 24'd0, 24'd0, 24'd0, 24'd0, 1'b1, 27'd2, 1'b0}},
      '{0, 1, '{24'd1, 24'd3, 24'd0, 24'd0, 24'd0, 1'b1, 27'd3, 1'b1}},
      '{0, 1, '{24'd0, 24'd1, 24'd0, 24'd0, 24'd0, 1'b1, 27'd0, 1'b0}},
      // Restart in the middle of the walk goes back to face 0.
      '{1, 1, '{24'd0, 24'd1, 24'd0, 24'd0, 24'd0, 1'b1, 27'd0, 1'b0}},
      '{0, 0, '{default: '0}},
      '{1, 0, '{default: '0}},
      '{0, 0, '{default: '0}}
   };

   // Main sequence: reset, directed rows, extreme meshes, then phases of random meshes.
   initial begin
      int ph, k, n;
      face_type blank;
      blank = '{default: '0};
      mesh_3d = 0; pts_i = 2; pts_j = 2; pts_k = 2;
      rewind_mesh();
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (directed_rows[r])
         send_request(directed_rows[r].restart, directed_rows[r].known,
                      directed_rows[r].face);
      drain_results();

      // Extreme meshes: the largest 3D grid, then a clamped small 2D grid.
      write_csr(CSR_POINTS_I, 511);
      write_csr(CSR_POINTS_J, 256);
      write_csr(CSR_POINTS_K, 300);
      write_csr(CSR_THREE_D, 1);
      for (k = 0; k < 8; k++) send_request(k == 5, 0, blank);
      drain_results();
      write_csr(CSR_THREE_D, 0);
      write_csr(CSR_POINTS_I, 0);
      write_csr(CSR_POINTS_J, 1);
      for (k = 0; k < 6; k++) send_request(0, 0, blank);
      drain_results();

      for (ph = 0; ph < 12; ph++) begin
         sender_gaps = (ph % 3) != 0;
         receiver_gaps = (ph % 4) != 1;
         write_csr(CSR_POINTS_I, pick_count());
         write_csr(CSR_POINTS_J, pick_count());
         write_csr(CSR_POINTS_K, pick_count());
         write_csr(CSR_THREE_D, (ph == 11) ? 0 : $urandom_range(1));
         if (ph == 2) hold_cycles = 400;
         n = 140 + $urandom_range(20);
         for (k = 0; k < n; k++) send_request($urandom_range(39) == 0, 0, blank);
         drain_results();
      end

      repeat (20) @(posedge clock);
      if (failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
`default_nettype wire

// ----- structured_grid_face_generator_unit.f -----
rtl/sgfg_pkg.sv
rtl/sgfg_ctrl.sv
rtl/sgfg_datapath.sv
rtl/structured_grid_face_generator_unit.sv
verif/structured_grid_face_generator_unit_test.sv
